### rtl/core/tcce_pkg.sv
// tcce_pkg: shared types and constants of the text console cursor engine
// holds command codes, character codes, register indexes and the control/datapath bundles
// no dependencies
`default_nettype none

package tcce_pkg;

    // fixed field widths
    localparam int POS_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 7;

    // item commands
    typedef enum logic [1:0] {
        CMD_PUT         = 2'd0,
        CMD_SCROLL_UP   = 2'd1,
        CMD_SCROLL_DOWN = 2'd2,
        CMD_READ        = 2'd3
    } t_cmd;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NEWLINE       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB           = 8'h09;
    localparam logic [BYTE_W-1:0] CH_COLOR_FIRST   = 8'h01;
    localparam logic [BYTE_W-1:0] CH_COLOR_DEFAULT = 8'h06;
    localparam logic [BYTE_W-1:0] CH_BLANK         = 8'h20;

    // colour of a cell after reset
    localparam logic [BYTE_W-1:0] RESET_COLOR = 8'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_DEFAULT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TAB        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE_FOUR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE_FIVE  = 3'd6;
    // colour code n selects register n + 1
    localparam logic [CFG_IDX_W-1:0] REG_CODE_OFFSET      = 3'd1;

    // register reset values
    localparam logic [BYTE_W-1:0] COLOR_DEFAULT_RST    = 8'd7;
    localparam logic [BYTE_W-1:0] COLOR_TAB_RST        = 8'd1;
    localparam logic [BYTE_W-1:0] COLOR_CODE_ONE_RST   = 8'd4;
    localparam logic [BYTE_W-1:0] COLOR_CODE_TWO_RST   = 8'd2;
    localparam logic [BYTE_W-1:0] COLOR_CODE_THREE_RST = 8'd9;
    localparam logic [BYTE_W-1:0] COLOR_CODE_FOUR_RST  = 8'd12;
    localparam logic [BYTE_W-1:0] COLOR_CODE_FIVE_RST  = 8'd10;

    typedef logic [NUM_REGS-1:0][BYTE_W-1:0] t_color_file;

    typedef enum logic [2:0] {
        CC_NEWLINE,
        CC_BACKSPACE,
        CC_TAB,
        CC_COLOR,
        CC_PRINT
    } t_char_class;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_NL_FIN,
        ST_POP,
        ST_BS_CLR,
        ST_TAB,
        ST_SCROLL,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic clear_write;
        logic scroll_up;
        logic scroll_down;
        logic rd_issue;
        logic rd_capture;
        logic push;
        logic put_char;
        logic set_color;
        logic div_start;
        logic nl_finish;
        logic pop_issue;
        logic pop_capture;
        logic bs_empty;
        logic bs_write;
        logic tab_start;
        logic tab_write;
        logic auto_scroll;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd        cmd;
        t_char_class cclass;
        logic        room_nl;
        logic        room_tab;
        logic        room_chr;
        logic        cur_nonzero;
        logic        stack_empty;
        logic        addr_ok;
        logic        bs_more;
        logic        tab_last;
        logic        scroll_need;
        logic        clear_last;
    } t_dp_status;

    function automatic t_char_class char_class(input logic [BYTE_W-1:0] ch);
        t_char_class cc;
        unique case (ch) inside
            CH_NEWLINE:                        cc = CC_NEWLINE;
            CH_BACKSPACE:                      cc = CC_BACKSPACE;
            CH_TAB:                            cc = CC_TAB;
            [CH_COLOR_FIRST:CH_COLOR_DEFAULT]: cc = CC_COLOR;
            default:                           cc = CC_PRINT;
        endcase
        return cc;
    endfunction

endpackage

`default_nettype wire

### rtl/core/text_console_cursor_engine.sv
// text_console_cursor_engine: top level of the text console engine
// holds colour registers and the result register; uses tcce_pkg, tcce_ctrl, tcce_dpath
`default_nettype none

// Text-mode console: a store of MEM_CELLS cells (character and colour byte), a
// cursor, a view base and a stack of earlier cursor positions for backspace.
// Commands: put character, scroll up, scroll down, read cell; each transfer in
// gives exactly one result transfer out. After reset the block blanks every cell
// of the store (blank with colour 7) and stalls input meanwhile; colour register
// writes are taken at any time. One item is worked on at a time by a state
// machine driving a datapath with a single store write port. A newline finds the
// line number by a reciprocal multiply, then the next line start; a tab fills
// TAB_CELLS cells one by one; a backspace pops a position from the stack (or
// goes to cell zero when the stack is empty) and clears the cells from there up
// to the old cursor one by one. A put then scrolls the view down line by line,
// as far as the scroll-down limit allows, to bring the cursor back into sight,
// and the result is held back while an earlier result still sits stalled in
// the output register. The next item is taken while a finished result still
// waits there.
module text_console_cursor_engine #(
    parameter int MEM_CELLS    = 2048,
    parameter int LINE_WIDTH   = 80,
    parameter int SCREEN_CELLS = 2000,
    parameter int TAB_CELLS    = 4,
    parameter int STACK_DEPTH  = 2048
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input items
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire [1:0]                          i_command,
    input  wire [tcce_pkg::BYTE_W-1:0]         i_char_code,
    input  wire [tcce_pkg::POS_W-1:0]          i_cell_address,
    // results
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [tcce_pkg::POS_W-1:0]         o_cursor_position,
    output logic [tcce_pkg::POS_W-1:0]         o_view_start,
    output logic [tcce_pkg::BYTE_W-1:0]        o_read_char,
    output logic [tcce_pkg::BYTE_W-1:0]        o_read_color,
    // colour register writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [tcce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [tcce_pkg::BYTE_W-1:0]         i_cfg_data
);

    tcce_pkg::t_dp_cmd     dp_cmd;
    tcce_pkg::t_dp_status  dp_stat;
    tcce_pkg::t_color_file r_colors;

    logic                        r_out_valid;
    logic [tcce_pkg::POS_W-1:0]  r_out_cursor;
    logic [tcce_pkg::POS_W-1:0]  r_out_view;
    logic [tcce_pkg::BYTE_W-1:0] r_out_char;
    logic [tcce_pkg::BYTE_W-1:0] r_out_color;

    logic                        out_free;
    logic                        out_load;
    logic [tcce_pkg::POS_W-1:0]  dp_cursor;
    logic [tcce_pkg::POS_W-1:0]  dp_view;
    logic [tcce_pkg::BYTE_W-1:0] dp_rd_char;
    logic [tcce_pkg::BYTE_W-1:0] dp_rd_color;

    // colour registers, always ready; indexes past the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors[tcce_pkg::REG_COLOR_DEFAULT]    <= tcce_pkg::COLOR_DEFAULT_RST;
            r_colors[tcce_pkg::REG_COLOR_TAB]        <= tcce_pkg::COLOR_TAB_RST;
            r_colors[tcce_pkg::REG_COLOR_CODE_ONE]   <= tcce_pkg::COLOR_CODE_ONE_RST;
            r_colors[tcce_pkg::REG_COLOR_CODE_TWO]   <= tcce_pkg::COLOR_CODE_TWO_RST;
            r_colors[tcce_pkg::REG_COLOR_CODE_THREE] <= tcce_pkg::COLOR_CODE_THREE_RST;
            r_colors[tcce_pkg::REG_COLOR_CODE_FOUR]  <= tcce_pkg::COLOR_CODE_FOUR_RST;
            r_colors[tcce_pkg::REG_COLOR_CODE_FIVE]  <= tcce_pkg::COLOR_CODE_FIVE_RST;
        end else if (i_cfg_valid && (i_cfg_index < tcce_pkg::NUM_REGS)) begin
            r_colors[i_cfg_index] <= i_cfg_data;
        end
    end

    // result register: free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded only when the slot is free
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cursor <= dp_cursor;
            r_out_view   <= dp_view;
            r_out_char   <= dp_rd_char;
            r_out_color  <= dp_rd_color;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_cursor;
    assign o_view_start      = r_out_view;
    assign o_read_char       = r_out_char;
    assign o_read_color      = r_out_color;

    // sequencer
    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_out_load (out_load),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // store, stack, cursor and view
    tcce_dpath #(
        .MEM_CELLS    (MEM_CELLS),
        .LINE_WIDTH   (LINE_WIDTH),
        .SCREEN_CELLS (SCREEN_CELLS),
        .TAB_CELLS    (TAB_CELLS),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_colors          (r_colors),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_cell_address    (i_cell_address),
        .o_cursor_position (dp_cursor),
        .o_view_start      (dp_view),
        .o_read_char       (dp_rd_char),
        .o_read_color      (dp_rd_color)
    );

endmodule

`default_nettype wire

### rtl/core/tcce_ctrl.sv
// tcce_ctrl: sequencing state machine of the console engine
// depends on tcce_pkg; drives tcce_dpath through command and status bundles
`default_nettype none

module tcce_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_out_free,
    output logic                  o_out_load,
    input  tcce_pkg::t_dp_status  i_stat,
    output tcce_pkg::t_dp_cmd     o_cmd
);

    tcce_pkg::t_state r_state;
    tcce_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcce_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_load = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tcce_pkg::ST_CLEAR: begin
                o_cmd.clear_write = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = tcce_pkg::ST_DECODE;
                end
            end
            tcce_pkg::ST_DECODE: begin
                unique case (i_stat.cmd)
                    tcce_pkg::CMD_SCROLL_UP: begin
                        o_cmd.scroll_up = 1'b1;
                        n_state         = tcce_pkg::ST_DONE;
                    end
                    tcce_pkg::CMD_SCROLL_DOWN: begin
                        o_cmd.scroll_down = 1'b1;
                        n_state           = tcce_pkg::ST_DONE;
                    end
                    tcce_pkg::CMD_READ: begin
                        if (i_stat.addr_ok) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = tcce_pkg::ST_RD_WAIT;
                        end else begin
                            n_state = tcce_pkg::ST_DONE;
                        end
                    end
                    tcce_pkg::CMD_PUT: begin
                        n_state = tcce_pkg::ST_SCROLL;
                        unique case (i_stat.cclass)
                            tcce_pkg::CC_NEWLINE: begin
                                if (i_stat.room_nl) begin
                                    o_cmd.push      = 1'b1;
                                    o_cmd.div_start = 1'b1;
                                    n_state         = tcce_pkg::ST_NL_FIN;
                                end
                            end
                            tcce_pkg::CC_BACKSPACE: begin
                                if (i_stat.cur_nonzero) begin
                                    if (i_stat.stack_empty) begin
                                        o_cmd.bs_empty = 1'b1;
                                        n_state        = tcce_pkg::ST_BS_CLR;
                                    end else begin
                                        o_cmd.pop_issue = 1'b1;
                                        n_state         = tcce_pkg::ST_POP;
                                    end
                                end
                            end
                            tcce_pkg::CC_TAB: begin
                                if (i_stat.room_tab) begin
                                    o_cmd.push      = 1'b1;
                                    o_cmd.tab_start = 1'b1;
                                    n_state         = tcce_pkg::ST_TAB;
                                end
                            end
                            tcce_pkg::CC_COLOR: begin
                                o_cmd.set_color = 1'b1;
                            end
                            default: begin
                                if (i_stat.room_chr) begin
                                    o_cmd.push     = 1'b1;
                                    o_cmd.put_char = 1'b1;
                                end
                            end
                        endcase
                    end
                    default: begin
                        n_state = tcce_pkg::ST_DONE;
                    end
                endcase
            end
            tcce_pkg::ST_RD_WAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = tcce_pkg::ST_DONE;
            end
            tcce_pkg::ST_NL_FIN: begin
                o_cmd.nl_finish = 1'b1;
                n_state         = tcce_pkg::ST_SCROLL;
            end
            tcce_pkg::ST_POP: begin
                o_cmd.pop_capture = 1'b1;
                n_state           = tcce_pkg::ST_BS_CLR;
            end
            tcce_pkg::ST_BS_CLR: begin
                if (i_stat.bs_more) begin
                    o_cmd.bs_write = 1'b1;
                end else begin
                    n_state = tcce_pkg::ST_SCROLL;
                end
            end
            tcce_pkg::ST_TAB: begin
                o_cmd.tab_write = 1'b1;
                if (i_stat.tab_last) begin
                    n_state = tcce_pkg::ST_SCROLL;
                end
            end
            tcce_pkg::ST_SCROLL: begin
                if (i_stat.scroll_need) begin
                    o_cmd.auto_scroll = 1'b1;
                end else begin
                    n_state = tcce_pkg::ST_DONE;
                end
            end
            tcce_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = tcce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/tcce_dpath.sv
// tcce_dpath: cell store, position stack, cursor and view registers, line divider
// depends on tcce_pkg; controlled by tcce_ctrl through command and status bundles
`default_nettype none

module tcce_dpath #(
    parameter int MEM_CELLS    = 2048,
    parameter int LINE_WIDTH   = 80,
    parameter int SCREEN_CELLS = 2000,
    parameter int TAB_CELLS    = 4,
    parameter int STACK_DEPTH  = 2048
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  tcce_pkg::t_dp_cmd                    i_cmd,
    output tcce_pkg::t_dp_status                 o_stat,
    input  tcce_pkg::t_color_file                i_colors,
    input  wire [1:0]                            i_command,
    input  wire [tcce_pkg::BYTE_W-1:0]           i_char_code,
    input  wire [tcce_pkg::POS_W-1:0]            i_cell_address,
    output logic [tcce_pkg::POS_W-1:0]           o_cursor_position,
    output logic [tcce_pkg::POS_W-1:0]           o_view_start,
    output logic [tcce_pkg::BYTE_W-1:0]          o_read_char,
    output logic [tcce_pkg::BYTE_W-1:0]          o_read_color
);

    localparam int CW    = $clog2(MEM_CELLS);
    localparam int VW    = $clog2(MEM_CELLS + LINE_WIDTH);
    localparam int SUMW  = $clog2(MEM_CELLS + SCREEN_CELLS + LINE_WIDTH + TAB_CELLS + 1);
    localparam int XW    = (SUMW > tcce_pkg::POS_W) ? SUMW : tcce_pkg::POS_W;
    localparam int LWW   = $clog2(LINE_WIDTH);
    localparam int TKW   = $clog2(TAB_CELLS + 1);
    localparam int SIW   = $clog2(STACK_DEPTH);
    localparam int CNTW  = $clog2(STACK_DEPTH + 1);
    localparam int CELLW = 2 * tcce_pkg::BYTE_W;
    // cursor / LINE_WIDTH as (cursor * QMUL) >> QSH, exact for any cursor below 2**CW
    localparam int QSH   = CW + LWW;
    localparam int QMUL  = ((1 << QSH) + LINE_WIDTH - 1) / LINE_WIDTH;
    localparam int QPW   = 2 * CW + 1;
    localparam int QW    = QPW - QSH;

    // storage
    logic [CELLW-1:0] r_store [MEM_CELLS];
    logic [CW-1:0]    r_stack [STACK_DEPTH];

    // item
    tcce_pkg::t_cmd              r_cmd;
    logic [tcce_pkg::BYTE_W-1:0] r_char;
    logic [tcce_pkg::POS_W-1:0]  r_addr;

    // console state
    logic [CW-1:0]               r_cursor;
    logic [VW-1:0]               r_vb;
    logic [tcce_pkg::BYTE_W-1:0] r_cur_color;
    logic [CNTW-1:0]             r_count;
    logic [CW-1:0]               r_clr_addr;

    // working registers
    logic [CELLW-1:0]            r_rd_q;
    logic [CW-1:0]               r_stk_q;
    logic [tcce_pkg::BYTE_W-1:0] r_rd_char;
    logic [tcce_pkg::BYTE_W-1:0] r_rd_color;
    logic [QW-1:0]               r_div_q;
    logic [CW-1:0]               r_ptr;
    logic [CW-1:0]               r_end;
    logic [TKW-1:0]              r_tab_k;

    // derived values
    logic [XW-1:0]                 cur_x;
    logic [XW-1:0]                 vb_x;
    logic [XW-1:0]                 addr_x;
    logic [XW-1:0]                 view_sum;
    logic                          down_ok;
    logic [QPW-1:0]                div_prod;
    logic [CW-1:0]                 nl_cursor;
    logic [SIW-1:0]                stk_push_idx;
    logic [SIW-1:0]                stk_pop_idx;
    logic                          stk_full;
    logic [tcce_pkg::CFG_IDX_W-1:0] col_idx;
    logic [tcce_pkg::BYTE_W-1:0]   sel_color;
    logic                          st_we;
    logic [CW-1:0]                 st_waddr;
    logic [CELLW-1:0]              st_wdata;

    assign cur_x    = XW'(r_cursor);
    assign vb_x     = XW'(r_vb);
    assign addr_x   = XW'(r_addr);
    assign view_sum = vb_x + XW'(SCREEN_CELLS);
    assign down_ok  = view_sum < XW'(MEM_CELLS);

    // line number by reciprocal multiply into r_div_q, line start of the next line from the registered quotient
    assign div_prod  = QPW'(r_cursor) * QPW'(QMUL);
    assign nl_cursor = CW'((XW'(r_div_q) + XW'(1)) * XW'(LINE_WIDTH));

    assign stk_push_idx = SIW'(r_count);
    assign stk_pop_idx  = SIW'(r_count - CNTW'(1));
    assign stk_full     = r_count >= CNTW'(STACK_DEPTH);

    assign col_idx   = r_char[tcce_pkg::CFG_IDX_W-1:0] + tcce_pkg::REG_CODE_OFFSET;
    assign sel_color = (r_char == tcce_pkg::CH_COLOR_DEFAULT)
                     ? i_colors[tcce_pkg::REG_COLOR_DEFAULT] : i_colors[col_idx];

    // status
    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.cclass      = tcce_pkg::char_class(r_char);
        o_stat.room_nl     = (cur_x + XW'(LINE_WIDTH)) < XW'(MEM_CELLS);
        o_stat.room_tab    = (cur_x + XW'(TAB_CELLS)) < XW'(MEM_CELLS);
        o_stat.room_chr    = (cur_x + XW'(1)) < XW'(MEM_CELLS);
        o_stat.cur_nonzero = r_cursor != '0;
        o_stat.stack_empty = r_count == '0;
        o_stat.addr_ok     = addr_x < XW'(MEM_CELLS);
        o_stat.bs_more     = r_ptr < r_end;
        o_stat.tab_last    = r_tab_k == TKW'(TAB_CELLS - 1);
        o_stat.scroll_need = (cur_x >= view_sum) && down_ok;
        o_stat.clear_last  = r_clr_addr == CW'(MEM_CELLS - 1);
    end

    // store write port
    always_comb begin
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        if (i_cmd.clear_write) begin
            st_we    = 1'b1;
            st_waddr = r_clr_addr;
            st_wdata = {tcce_pkg::CH_BLANK, tcce_pkg::RESET_COLOR};
        end else if (i_cmd.put_char) begin
            st_we    = 1'b1;
            st_waddr = r_cursor;
            st_wdata = {r_char, r_cur_color};
        end else if (i_cmd.tab_write) begin
            st_we    = 1'b1;
            st_waddr = r_cursor;
            st_wdata = {tcce_pkg::CH_BLANK, i_colors[tcce_pkg::REG_COLOR_TAB]};
        end else if (i_cmd.bs_write) begin
            st_we    = 1'b1;
            st_waddr = r_ptr;
            st_wdata = {tcce_pkg::CH_BLANK, i_colors[tcce_pkg::REG_COLOR_DEFAULT]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= st_wdata;
        end
        if (i_cmd.rd_issue) begin
            r_rd_q <= r_store[addr_x[CW-1:0]];
        end
    end

    // position stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !stk_full) begin
            r_stack[stk_push_idx] <= r_cursor;
        end
        if (i_cmd.pop_issue) begin
            r_stk_q <= r_stack[stk_pop_idx];
        end
    end

    // console state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_vb        <= '0;
            r_cur_color <= tcce_pkg::RESET_COLOR;
            r_count     <= '0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cmd.clear_write) begin
                r_clr_addr <= r_clr_addr + CW'(1);
            end
            if (i_cmd.push && !stk_full) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_cmd.pop_issue) begin
                r_count <= r_count - CNTW'(1);
            end
            if (i_cmd.set_color) begin
                r_cur_color <= sel_color;
            end
            if (i_cmd.put_char || i_cmd.tab_write) begin
                r_cursor <= r_cursor + CW'(1);
            end else if (i_cmd.nl_finish) begin
                r_cursor <= nl_cursor;
            end else if (i_cmd.pop_capture) begin
                r_cursor <= r_stk_q;
            end else if (i_cmd.bs_empty) begin
                r_cursor <= '0;
            end
            if (i_cmd.scroll_up) begin
                if (r_vb >= VW'(LINE_WIDTH)) begin
                    r_vb <= r_vb - VW'(LINE_WIDTH);
                end else begin
                    r_vb <= '0;
                end
            end else if ((i_cmd.scroll_down && down_ok) || i_cmd.auto_scroll) begin
                r_vb <= VW'(vb_x + XW'(LINE_WIDTH));
            end
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd      <= tcce_pkg::t_cmd'(i_command);
            r_char     <= i_char_code;
            r_addr     <= i_cell_address;
            r_rd_char  <= '0;
            r_rd_color <= '0;
        end else if (i_cmd.rd_capture) begin
            r_rd_char  <= r_rd_q[CELLW-1:tcce_pkg::BYTE_W];
            r_rd_color <= r_rd_q[tcce_pkg::BYTE_W-1:0];
        end
        if (i_cmd.div_start) begin
            r_div_q <= div_prod[QPW-1:QSH];
        end
        if (i_cmd.pop_capture) begin
            r_ptr <= r_stk_q;
            r_end <= r_cursor;
        end else if (i_cmd.bs_empty) begin
            r_ptr <= '0;
            r_end <= r_cursor;
        end else if (i_cmd.bs_write) begin
            r_ptr <= r_ptr + CW'(1);
        end
        if (i_cmd.tab_start) begin
            r_tab_k <= '0;
        end else if (i_cmd.tab_write) begin
            r_tab_k <= r_tab_k + TKW'(1);
        end
    end

    assign o_cursor_position = cur_x[tcce_pkg::POS_W-1:0];
    assign o_view_start      = vb_x[tcce_pkg::POS_W-1:0];
    assign o_read_char       = r_rd_char;
    assign o_read_color      = r_rd_color;

endmodule

`default_nettype wire

### tb/tcce_checker.sv
// tcce_checker: scoreboard for the text console cursor engine
// keeps a shadow console (cells, cursor, view, position stack, colours) and checks every result
// depends on tcce_pkg
module tcce_checker
    import tcce_pkg::*;
#(
    parameter int MEM_CELLS    = 2048,
    parameter int LINE_WIDTH   = 80,
    parameter int SCREEN_CELLS = 2000,
    parameter int TAB_CELLS    = 4,
    parameter int STACK_DEPTH  = 2048
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  wire [1:0]            i_command,
    input  wire [BYTE_W-1:0]     i_char_code,
    input  wire [POS_W-1:0]      i_cell_address,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  wire [POS_W-1:0]      i_cursor_position,
    input  wire [POS_W-1:0]      i_view_start,
    input  wire [BYTE_W-1:0]     i_read_char,
    input  wire [BYTE_W-1:0]     i_read_color,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [BYTE_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  view_pos;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_color;
    } console_view_t;

    logic [BYTE_W-1:0] glyph_mem [MEM_CELLS];
    logic [BYTE_W-1:0] shade_mem [MEM_CELLS];
    int                mark_stack [STACK_DEPTH];
    int                mark_count;
    int                cursor_now;
    int                view_now;
    logic [BYTE_W-1:0] pen_color;
    logic [BYTE_W-1:0] palette [NUM_REGS];
    console_view_t     pending_views [$];
    console_view_t     oldest;
    console_view_t     fresh;
    int                mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] console check: %s", $time, what);
        mismatches++;
    endtask

    // a full stack drops the push
    task automatic push_mark(input int pos);
        if (mark_count < STACK_DEPTH) begin
            mark_stack[mark_count] = pos;
            mark_count++;
        end
    endtask

    task automatic console_step(input logic [1:0] cmd_bits, input logic [BYTE_W-1:0] ch,
                                input logic [POS_W-1:0] addr, output console_view_t res);
        t_cmd op;
        int   prev;
        int   last;
        int   i;
        op  = t_cmd'(cmd_bits);
        res = '0;
        case (op)
            CMD_PUT: begin
                if (ch == CH_NEWLINE) begin
                    if (cursor_now + LINE_WIDTH < MEM_CELLS) begin
                        push_mark(cursor_now);
                        cursor_now = LINE_WIDTH * (cursor_now / LINE_WIDTH + 1);
                    end
                end else if (ch == CH_BACKSPACE) begin
                    if (cursor_now > 0) begin
                        prev = cursor_now;
                        if (mark_count == 0) begin
                            last = 0;
                        end else begin
                            mark_count--;
                            last = mark_stack[mark_count];
                        end
                        cursor_now = last;
                        for (i = last; i < prev && i < MEM_CELLS; i++) begin
                            glyph_mem[i] = CH_BLANK;
                            shade_mem[i] = palette[REG_COLOR_DEFAULT];
                        end
                    end
                end else if (ch == CH_TAB) begin
                    if (cursor_now + TAB_CELLS < MEM_CELLS) begin
                        push_mark(cursor_now);
                        for (i = 0; i < TAB_CELLS; i++) begin
                            glyph_mem[cursor_now + i] = CH_BLANK;
                            shade_mem[cursor_now + i] = palette[REG_COLOR_TAB];
                        end
                        cursor_now += TAB_CELLS;
                    end
                end else if (ch >= CH_COLOR_FIRST && ch < CH_COLOR_DEFAULT) begin
                    pen_color = palette[ch + REG_CODE_OFFSET];
                end else if (ch == CH_COLOR_DEFAULT) begin
                    pen_color = palette[REG_COLOR_DEFAULT];
                end else if (cursor_now + 1 < MEM_CELLS) begin
                    push_mark(cursor_now);
                    glyph_mem[cursor_now] = ch;
                    shade_mem[cursor_now] = pen_color;
                    cursor_now++;
                end
                // follow the cursor, but never past the scroll-down limit
                while (cursor_now >= view_now + SCREEN_CELLS &&
                       view_now + SCREEN_CELLS < MEM_CELLS)
                    view_now += LINE_WIDTH;
            end
            CMD_SCROLL_UP: begin
                if (view_now > 0)
                    view_now = (view_now >= LINE_WIDTH) ? view_now - LINE_WIDTH : 0;
            end
            CMD_SCROLL_DOWN: begin
                if (view_now + SCREEN_CELLS < MEM_CELLS)
                    view_now += LINE_WIDTH;
            end
            default: begin
                if (addr < MEM_CELLS) begin
                    res.cell_char  = glyph_mem[addr];
                    res.cell_color = shade_mem[addr];
                end
            end
        endcase
        res.cursor_pos = cursor_now[POS_W-1:0];
        res.view_pos   = view_now[POS_W-1:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MEM_CELLS; k++) begin
                glyph_mem[k] = CH_BLANK;
                shade_mem[k] = RESET_COLOR;
            end
            mark_count = 0;
            cursor_now = 0;
            view_now   = 0;
            pen_color  = RESET_COLOR;
            palette[REG_COLOR_DEFAULT]    = COLOR_DEFAULT_RST;
            palette[REG_COLOR_TAB]        = COLOR_TAB_RST;
            palette[REG_COLOR_CODE_ONE]   = COLOR_CODE_ONE_RST;
            palette[REG_COLOR_CODE_TWO]   = COLOR_CODE_TWO_RST;
            palette[REG_COLOR_CODE_THREE] = COLOR_CODE_THREE_RST;
            palette[REG_COLOR_CODE_FOUR]  = COLOR_CODE_FOUR_RST;
            palette[REG_COLOR_CODE_FIVE]  = COLOR_CODE_FIVE_RST;
            pending_views.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_REGS)
                palette[i_cfg_index] = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (pending_views.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    oldest = pending_views.pop_front();
                    if (i_cursor_position !== oldest.cursor_pos)
                        report_mismatch($sformatf("cursor_position got %0d want %0d",
                                                  i_cursor_position, oldest.cursor_pos));
                    if (i_view_start !== oldest.view_pos)
                        report_mismatch($sformatf("view_start got %0d want %0d",
                                                  i_view_start, oldest.view_pos));
                    if (i_read_char !== oldest.cell_char)
                        report_mismatch($sformatf("read_char got %h want %h",
                                                  i_read_char, oldest.cell_char));
                    if (i_read_color !== oldest.cell_color)
                        report_mismatch($sformatf("read_color got %h want %h",
                                                  i_read_color, oldest.cell_color));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                console_step(i_command, i_char_code, i_cell_address, fresh);
                pending_views.push_back(fresh);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_views.size();
    end

endmodule

### tb/tb_top.sv
// tb_top: testbench top for the text console cursor engine
// drives commands, colour writes and result back-pressure, then gives the verdict
// depends on tcce_pkg, text_console_cursor_engine and tcce_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tcce_pkg::*;

    localparam int MEM_CELLS    = 2048;
    localparam int LINE_WIDTH   = 80;
    localparam int SCREEN_CELLS = 2000;
    localparam int TAB_CELLS    = 4;
    localparam int STACK_DEPTH  = 2048;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_WAIT     = 10;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 100;
    localparam int TAIL_CYCLES  = 200;
    // store clear after reset plus a generous margin over the slowest item
    localparam int QUIET_LIMIT  = 20000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [1:0]            cmd       = CMD_PUT;
    logic [BYTE_W-1:0]     char_code = '0;
    logic [POS_W-1:0]      cell_addr = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_COLOR_DEFAULT;
    logic [BYTE_W-1:0]     cfg_data  = '0;

    wire                   in_stall;
    wire                   out_valid;
    wire                   cfg_ready;
    wire [POS_W-1:0]       cur_pos;
    wire [POS_W-1:0]       view_pos;
    wire [BYTE_W-1:0]      rd_char;
    wire [BYTE_W-1:0]      rd_color;
    int                    fail_count;
    int                    pending;

    // set while both sides run without gaps or stalls
    bit                    calm = 1'b0;
    logic                  out_fire_q = 1'b0;
    logic [POS_W-1:0]      last_cursor = '0;
    int                    stall_left = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    text_console_cursor_engine #(
        .MEM_CELLS    (MEM_CELLS),
        .LINE_WIDTH   (LINE_WIDTH),
        .SCREEN_CELLS (SCREEN_CELLS),
        .TAB_CELLS    (TAB_CELLS),
        .STACK_DEPTH  (STACK_DEPTH)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_command         (cmd),
        .i_char_code       (char_code),
        .i_cell_address    (cell_addr),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_cursor_position (cur_pos),
        .o_view_start      (view_pos),
        .o_read_char       (rd_char),
        .o_read_color      (rd_color),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    tcce_checker #(
        .MEM_CELLS    (MEM_CELLS),
        .LINE_WIDTH   (LINE_WIDTH),
        .SCREEN_CELLS (SCREEN_CELLS),
        .TAB_CELLS    (TAB_CELLS),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_command         (cmd),
        .i_char_code       (char_code),
        .i_cell_address    (cell_addr),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_cursor_position (cur_pos),
        .i_view_start      (view_pos),
        .i_read_char       (rd_char),
        .i_read_color      (rd_color),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // note each result transfer; the last cursor seen steers reads towards written cells
    always @(posedge clk) begin
        out_fire_q <= out_valid && !out_stall;
        if (out_valid && !out_stall)
            last_cursor <= cur_pos;
    end

    // result back-pressure: after each result transfer a fresh random stall is drawn, none while calm
    always @(negedge clk) begin
        if (out_fire_q)
            stall_left = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (stall_left > 0 && out_valid) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
        end
    end

    // one command transfer: optional gap with valid low, then hold until taken
    task automatic send_item(input logic [1:0] c, input logic [BYTE_W-1:0] ch,
                             input logic [POS_W-1:0] a);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        cmd       = c;
        char_code = ch;
        cell_addr = a;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // one colour register transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // let every outstanding result drain before touching the colour registers
    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // watchdog: ends the run after too long without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** text_console_cursor_engine: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [1:0]        c;
        logic [BYTE_W-1:0] ch;
        logic [POS_W-1:0]  a;
        int                roll;
        int                pick;
        int                nl_weight;
        int                bs_weight;
        int                back_off;
        int                mode;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // colour registers straight after reset, while the store is still being cleared;
        // an unused index is written too and must change nothing
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(CFG_IDX_W'(r), 8'($urandom_range(0, 255)));
        write_reg(CFG_IDX_W'(NUM_REGS), 8'($urandom_range(0, 255)));

        // directed: reset contents, edges of the store, every colour code, the controls
        send_item(CMD_READ, 8'h00, '0);
        send_item(CMD_READ, 8'hFF, '1);
        send_item(CMD_PUT, CH_BACKSPACE, '1);            // backspace at cell zero
        send_item(CMD_SCROLL_UP, 8'h55, 11'h2AA);        // scroll up at view zero
        send_item(CMD_PUT, 8'h00, 11'h555);              // code zero is printable
        send_item(CMD_PUT, CH_COLOR_FIRST, '0);
        send_item(CMD_PUT, 8'hFF, '0);
        send_item(CMD_PUT, CH_COLOR_FIRST + 8'd1, '0);
        send_item(CMD_PUT, 8'h41, '0);
        send_item(CMD_PUT, CH_COLOR_FIRST + 8'd2, '0);
        send_item(CMD_PUT, 8'h0D, '0);                   // carriage return is printable
        send_item(CMD_PUT, CH_COLOR_FIRST + 8'd3, '0);
        send_item(CMD_PUT, 8'h07, '0);
        send_item(CMD_PUT, CH_COLOR_FIRST + 8'd4, '0);
        send_item(CMD_PUT, 8'h0B, '0);
        send_item(CMD_PUT, CH_COLOR_DEFAULT, '0);
        send_item(CMD_PUT, 8'h7E, '0);
        send_item(CMD_PUT, CH_TAB, '0);
        send_item(CMD_READ, 8'h00, 11'd9);               // inside the tab fill
        send_item(CMD_PUT, CH_NEWLINE, '0);
        send_item(CMD_PUT, CH_BACKSPACE, '0);            // undo the newline, clear the line
        send_item(CMD_READ, 8'h00, 11'd40);
        send_item(CMD_SCROLL_DOWN, 8'h00, '0);
        send_item(CMD_SCROLL_DOWN, 8'h00, '0);           // already at the scroll-down limit
        send_item(CMD_SCROLL_UP, 8'h00, '0);
        send_item(CMD_PUT, CH_BACKSPACE, '0);            // undo the tab

        // random phases: plain typing, climbing to the end of the store, erasing back
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            for (int r = 0; r < NUM_REGS; r++) begin
                if (phase == 1)
                    write_reg(CFG_IDX_W'(r), 8'h00);
                else if (phase == 2)
                    write_reg(CFG_IDX_W'(r), 8'hFF);
                else if ($urandom_range(0, 2) != 0)
                    write_reg(CFG_IDX_W'(r), 8'($urandom_range(0, 255)));
            end
            mode      = phase % 3;
            calm      = (phase % 4 == 3);
            nl_weight = (mode == 1) ? 35 : 8;
            bs_weight = (mode == 2) ? 35 : 8;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                c    = CMD_PUT;
                ch   = 8'($urandom_range(0, 255));
                a    = POS_W'($urandom_range(0, MEM_CELLS - 1));
                roll = $urandom_range(0, 99);
                if (roll < 7) begin
                    c = CMD_SCROLL_UP;
                end else if (roll < 14) begin
                    c = CMD_SCROLL_DOWN;
                end else if (roll < 25) begin
                    c = CMD_READ;
                    // half the reads look just behind the cursor, where cells were written
                    if ($urandom_range(0, 1) != 0) begin
                        back_off = $urandom_range(0, LINE_WIDTH + 10);
                        if (last_cursor >= back_off)
                            a = POS_W'(last_cursor - back_off);
                    end
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < nl_weight)
                        ch = CH_NEWLINE;
                    else if (pick < nl_weight + bs_weight)
                        ch = CH_BACKSPACE;
                    else if (pick < nl_weight + bs_weight + 8)
                        ch = CH_TAB;
                    else if (pick < nl_weight + bs_weight + 16)
                        ch = 8'($urandom_range(CH_COLOR_FIRST, CH_COLOR_DEFAULT));
                end
                send_item(c, ch, a);
            end
        end

        // wrap up: drain, give the block time to show any stray result, then verdict
        drain();
        calm = 1'b0;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** text_console_cursor_engine: PASSED **");
        else
            $display("** text_console_cursor_engine: FAILED **");
        $finish;
    end

endmodule
